### design/assert_macros.svh
// Assertion macros for the gradient renderer RTL
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef ASSERT_OFF

// expression must never hold outside reset
`define ASSERT_NEVER(lbl, clk_s, rst_s, expr) \
  lbl: assert property (@(posedge clk_s) disable iff (rst_s) !(expr)) \
    else $error("forbidden condition seen");

// antecedent implies consequent in the same cycle
`define ASSERT_IMPL(lbl, clk_s, rst_s, ante, cons) \
  lbl: assert property (@(posedge clk_s) disable iff (rst_s) (ante) |-> (cons)) \
    else $error("implication failed");

// antecedent implies consequent in the next cycle
`define ASSERT_NEXT(lbl, clk_s, rst_s, ante, cons) \
  lbl: assert property (@(posedge clk_s) disable iff (rst_s) (ante) |=> (cons)) \
    else $error("next-cycle implication failed");

`else

`define ASSERT_NEVER(lbl, clk_s, rst_s, expr)
`define ASSERT_IMPL(lbl, clk_s, rst_s, ante, cons)
`define ASSERT_NEXT(lbl, clk_s, rst_s, ante, cons)

`endif

`endif

### design/lgr_pkg.sv
// Shared types and constants for the linear gradient renderer
`default_nettype none

package lgr_pkg;

  // fixed field widths
  localparam int START_BITS        = 19;
  localparam int COEF_BITS         = 40;
  localparam int COLOR_BITS        = 64;
  localparam int SLOT_BITS         = 16;
  localparam int REGION_COORD_BITS = 25;
  localparam int REGION_WIDTH_BITS = 15;
  localparam int CHUNK_BITS        = 17;   // signed multiplier operand for one coefficient slice
  localparam int W_BITS            = 17;   // weight 0..65536

  // APB port
  localparam int APB_ADDR_BITS = 6;
  localparam int APB_DATA_BITS = 64;

  // register indexes
  localparam logic [2:0] REG_START_X    = 3'd0;
  localparam logic [2:0] REG_START_Y    = 3'd1;
  localparam logic [2:0] REG_COEF_X     = 3'd2;
  localparam logic [2:0] REG_COEF_Y     = 3'd3;
  localparam logic [2:0] REG_COLOR_NEAR = 3'd4;
  localparam logic [2:0] REG_COLOR_FAR  = 3'd5;
  localparam logic [2:0] REG_FLAT_MODE  = 3'd6;

  // register reset values
  localparam logic [START_BITS-1:0] RST_START = START_BITS'(6400);
  localparam logic [COEF_BITS-1:0]  RST_COEF  = COEF_BITS'(17179869);
  localparam logic [COLOR_BITS-1:0] RST_NEAR  = COLOR_BITS'(65535);

  // weight constants
  localparam logic [W_BITS-1:0] WEIGHT_ONE  = W_BITS'(65536);
  localparam logic [W_BITS-1:0] WEIGHT_HALF = W_BITS'(32768);
  localparam logic [W_BITS-1:0] WEIGHT_ZERO = '0;
  localparam int ROUND_HALF = 32768;

  // coefficient slice codes
  localparam logic [1:0] CHUNK_LO  = 2'd0;
  localparam logic [1:0] CHUNK_MID = 2'd1;
  localparam logic [1:0] CHUNK_HI  = 2'd2;

  // colour channel codes
  localparam logic [1:0] CH_RED   = 2'd0;
  localparam logic [1:0] CH_GREEN = 2'd1;
  localparam logic [1:0] CH_BLUE  = 2'd2;
  localparam logic [1:0] CH_ALPHA = 2'd3;

  // sequencer step limits
  localparam logic [2:0] MUL_LAST   = 3'd5;
  localparam logic [2:0] AXIS_STEPS = 3'd3;
  localparam logic [2:0] BLEND_LAST = 3'd3;

  // configuration register contents
  typedef struct packed {
    logic [START_BITS-1:0] start_x;
    logic [START_BITS-1:0] start_y;
    logic [COEF_BITS-1:0]  coef_x;
    logic [COEF_BITS-1:0]  coef_y;
    logic [COLOR_BITS-1:0] color_near;
    logic [COLOR_BITS-1:0] color_far;
    logic                  flat_mode;
  } cfg_t;

  // controller to datapath commands
  typedef struct packed {
    logic       capture;      // input beat taken
    logic       diff;         // form offsets, step coordinates, clear accumulator
    logic       mul_issue;    // one coefficient partial product
    logic       mul_axis;     // 0 x, 1 y
    logic [1:0] mul_chunk;
    logic       acc_add;      // add last partial product
    logic       weight;       // clamp accumulator to weight
    logic       blend_issue;  // one channel product
    logic [1:0] blend_chan;
    logic       blend_add;    // finish last channel
    logic       load_out;     // move result to output register
  } cmd_t;

endpackage

`default_nettype wire

### design/linear_gradient_renderer_top.sv
// Top level of the linear two-colour gradient pixel generator
//
//  Channel  Handshake               Beat contents
//  pix      pix_valid / pix_ready   new_region, region_x, region_y, region_width
//  rgba     rgba_valid / rgba_ready red, green, blue, alpha
//  config   APB psel/penable/pready 64-bit registers at byte address 8*index
//
// Pixels are processed one at a time: after the accepting edge the offsets
// are formed, the two 40-bit coefficients are fed slice by slice through one
// shared offset-by-17-bit multiplier, then weight clamp and four blend
// products on a second multiplier. rst is synchronous; the block is ready in
// the first cycle after reset. A result waits in the output register; the next
// pixel is computed meanwhile and held until that beat is taken.
`default_nettype none

module linear_gradient_renderer_top import lgr_pkg::*; #(
  parameter int COORD_BITS    = 25,
  parameter int CHANNEL_BITS  = 16,
  parameter int MAX_ROW_WIDTH = 16384
) (
  input  wire logic                         clk,
  input  wire logic                         rst,
  // pixel ticks
  input  wire logic                         pix_valid,
  output logic                              pix_ready,
  input  wire logic                         new_region,
  input  wire logic [REGION_COORD_BITS-1:0] region_x,
  input  wire logic [REGION_COORD_BITS-1:0] region_y,
  input  wire logic [REGION_WIDTH_BITS-1:0] region_width,
  // blended pixels
  output logic                              rgba_valid,
  input  wire logic                         rgba_ready,
  output logic      [CHANNEL_BITS-1:0]      red,
  output logic      [CHANNEL_BITS-1:0]      green,
  output logic      [CHANNEL_BITS-1:0]      blue,
  output logic      [CHANNEL_BITS-1:0]      alpha,
  // configuration
  input  wire logic                         psel,
  input  wire logic                         penable,
  input  wire logic                         pwrite,
  input  wire logic [APB_ADDR_BITS-1:0]     paddr,
  input  wire logic [APB_DATA_BITS-1:0]     pwdata,
  output logic      [APB_DATA_BITS-1:0]     prdata,
  output logic                              pready
);

  cfg_t cfg;
  cmd_t cmd;

  lgr_regs u_regs (
    .clk     (clk),
    .rst     (rst),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg     (cfg)
  );

  lgr_ctrl u_ctrl (
    .clk        (clk),
    .rst        (rst),
    .pix_valid  (pix_valid),
    .pix_ready  (pix_ready),
    .rgba_valid (rgba_valid),
    .rgba_ready (rgba_ready),
    .cmd        (cmd)
  );

  lgr_datapath #(
    .COORD_BITS    (COORD_BITS),
    .CHANNEL_BITS  (CHANNEL_BITS),
    .MAX_ROW_WIDTH (MAX_ROW_WIDTH)
  ) u_datapath (
    .clk          (clk),
    .rst          (rst),
    .cmd          (cmd),
    .cfg          (cfg),
    .new_region   (new_region),
    .region_x     (region_x),
    .region_y     (region_y),
    .region_width (region_width),
    .red          (red),
    .green        (green),
    .blue         (blue),
    .alpha        (alpha)
  );

endmodule

`default_nettype wire

### design/lgr_regs.sv
// APB configuration register file for the gradient renderer
`default_nettype none

module lgr_regs import lgr_pkg::*; (
  input  wire logic                     clk,
  input  wire logic                     rst,
  input  wire logic                     psel,
  input  wire logic                     penable,
  input  wire logic                     pwrite,
  input  wire logic [APB_ADDR_BITS-1:0] paddr,
  input  wire logic [APB_DATA_BITS-1:0] pwdata,
  output logic      [APB_DATA_BITS-1:0] prdata,
  output logic                          pready,
  output cfg_t                          cfg
);

  logic       wr;
  logic [2:0] idx;

  assign pready = 1'b1;
  assign wr     = psel & penable & pwrite;
  assign idx    = paddr[APB_ADDR_BITS-1:3];

  // register writes
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.start_x    <= RST_START;
      cfg.start_y    <= RST_START;
      cfg.coef_x     <= RST_COEF;
      cfg.coef_y     <= RST_COEF;
      cfg.color_near <= RST_NEAR;
      cfg.color_far  <= '1;
      cfg.flat_mode  <= 1'b0;
    end else if (wr) begin
      unique case (idx)
        REG_START_X:    cfg.start_x    <= pwdata[START_BITS-1:0];
        REG_START_Y:    cfg.start_y    <= pwdata[START_BITS-1:0];
        REG_COEF_X:     cfg.coef_x     <= pwdata[COEF_BITS-1:0];
        REG_COEF_Y:     cfg.coef_y     <= pwdata[COEF_BITS-1:0];
        REG_COLOR_NEAR: cfg.color_near <= pwdata[COLOR_BITS-1:0];
        REG_COLOR_FAR:  cfg.color_far  <= pwdata[COLOR_BITS-1:0];
        REG_FLAT_MODE:  cfg.flat_mode  <= pwdata[0];
        default: ;
      endcase
    end
  end

  // read-back
  always_comb begin
    unique case (idx)
      REG_START_X:    prdata = APB_DATA_BITS'(cfg.start_x);
      REG_START_Y:    prdata = APB_DATA_BITS'(cfg.start_y);
      REG_COEF_X:     prdata = APB_DATA_BITS'(cfg.coef_x);
      REG_COEF_Y:     prdata = APB_DATA_BITS'(cfg.coef_y);
      REG_COLOR_NEAR: prdata = APB_DATA_BITS'(cfg.color_near);
      REG_COLOR_FAR:  prdata = APB_DATA_BITS'(cfg.color_far);
      REG_FLAT_MODE:  prdata = APB_DATA_BITS'(cfg.flat_mode);
      default:        prdata = '0;
    endcase
  end

endmodule

`default_nettype wire

### design/lgr_ctrl.sv
// Sequencer for the gradient renderer: steps one pixel through the datapath
`default_nettype none
`include "assert_macros.svh"

module lgr_ctrl import lgr_pkg::*; (
  input  wire logic clk,
  input  wire logic rst,
  input  wire logic pix_valid,
  output logic      pix_ready,
  output logic      rgba_valid,
  input  wire logic rgba_ready,
  output cmd_t      cmd
);

  localparam logic [2:0] ST_IDLE   = 3'd0;
  localparam logic [2:0] ST_DIFF   = 3'd1;
  localparam logic [2:0] ST_MUL    = 3'd2;
  localparam logic [2:0] ST_MACC   = 3'd3;
  localparam logic [2:0] ST_WEIGHT = 3'd4;
  localparam logic [2:0] ST_BLEND  = 3'd5;
  localparam logic [2:0] ST_BLAST  = 3'd6;
  localparam logic [2:0] ST_WRITE  = 3'd7;

  logic [2:0] state, state_next;
  logic [2:0] cnt, cnt_next;
  logic [2:0] cnt_y;
  logic       out_free;

  assign out_free = !rgba_valid || rgba_ready;
  assign cnt_y    = cnt - AXIS_STEPS;

  // next state and commands
  always_comb begin
    state_next = state;
    cnt_next   = cnt;
    pix_ready  = 1'b0;
    cmd        = '0;
    unique case (state)
      ST_IDLE: begin
        pix_ready = 1'b1;
        if (pix_valid) begin
          cmd.capture = 1'b1;
          state_next  = ST_DIFF;
        end
      end
      ST_DIFF: begin
        cmd.diff   = 1'b1;
        cnt_next   = '0;
        state_next = ST_MUL;
      end
      ST_MUL: begin
        cmd.mul_issue = 1'b1;
        cmd.mul_axis  = (cnt >= AXIS_STEPS);
        cmd.mul_chunk = (cnt >= AXIS_STEPS) ? cnt_y[1:0] : cnt[1:0];
        cmd.acc_add   = (cnt != '0);
        if (cnt == MUL_LAST) begin
          state_next = ST_MACC;
        end else begin
          cnt_next = cnt + 3'd1;
        end
      end
      ST_MACC: begin
        cmd.acc_add = 1'b1;
        state_next  = ST_WEIGHT;
      end
      ST_WEIGHT: begin
        cmd.weight = 1'b1;
        cnt_next   = '0;
        state_next = ST_BLEND;
      end
      ST_BLEND: begin
        cmd.blend_issue = 1'b1;
        cmd.blend_chan  = cnt[1:0];
        cmd.blend_add   = (cnt != '0);
        if (cnt == BLEND_LAST) begin
          state_next = ST_BLAST;
        end else begin
          cnt_next = cnt + 3'd1;
        end
      end
      ST_BLAST: begin
        cmd.blend_add = 1'b1;
        state_next    = ST_WRITE;
      end
      ST_WRITE: begin
        if (out_free) begin
          cmd.load_out = 1'b1;
          state_next   = ST_IDLE;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

  // state, step counter, output valid
  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= ST_IDLE;
      cnt        <= '0;
      rgba_valid <= 1'b0;
    end else begin
      state <= state_next;
      cnt   <= cnt_next;
      if (cmd.load_out) begin
        rgba_valid <= 1'b1;
      end else if (rgba_ready) begin
        rgba_valid <= 1'b0;
      end
    end
  end

  // a waiting result is never overwritten
  `ASSERT_NEVER(a_no_overwrite, clk, rst, cmd.load_out && rgba_valid && !rgba_ready)
  // an accepted beat starts the offset step
  `ASSERT_NEXT(a_accept_to_diff, clk, rst, pix_valid && pix_ready, state == ST_DIFF)
  // partial product counter stays within both axes
  `ASSERT_IMPL(a_mul_bound, clk, rst, state == ST_MUL, cnt <= MUL_LAST)
  // a new result follows the last blend step
  `ASSERT_NEXT(a_load_sets_valid, clk, rst, cmd.load_out, rgba_valid)

endmodule

`default_nettype wire

### design/lgr_datapath.sv
// Gradient datapath: coordinates, projection, weight clamp and colour blend
`default_nettype none

module lgr_datapath import lgr_pkg::*; #(
  parameter int COORD_BITS    = 25,
  parameter int CHANNEL_BITS  = 16,
  parameter int MAX_ROW_WIDTH = 16384
) (
  input  wire logic                         clk,
  input  wire logic                         rst,
  input  wire cmd_t                         cmd,
  input  wire cfg_t                         cfg,
  input  wire logic                         new_region,
  input  wire logic [REGION_COORD_BITS-1:0] region_x,
  input  wire logic [REGION_COORD_BITS-1:0] region_y,
  input  wire logic [REGION_WIDTH_BITS-1:0] region_width,
  output logic      [CHANNEL_BITS-1:0]      red,
  output logic      [CHANNEL_BITS-1:0]      green,
  output logic      [CHANNEL_BITS-1:0]      blue,
  output logic      [CHANNEL_BITS-1:0]      alpha
);

  localparam int DXW  = COORD_BITS + 9;
  localparam int PW   = DXW + CHUNK_BITS;
  localparam int ACCW = DXW + COEF_BITS + 1;
  localparam int WB   = $clog2(MAX_ROW_WIDTH + 1);
  localparam int CMPW = (COORD_BITS + 1 > WB) ? COORD_BITS + 1 : WB;
  localparam int BPW  = CHANNEL_BITS + 1 + W_BITS + 1;
  localparam int SW   = CHANNEL_BITS + 20;

  // coordinate state
  logic [COORD_BITS-1:0] cur_x, cur_y, row_left;
  logic [WB-1:0]         row_width_held;

  // projection
  logic signed [DXW-1:0]  dx, dy;
  logic signed [PW-1:0]   prod;
  logic [1:0]             chunk_d;
  logic signed [ACCW-1:0] acc;
  logic [W_BITS-1:0]      w;

  // blend
  logic signed [BPW-1:0]   bprod;
  logic [CHANNEL_BITS-1:0] bf;
  logic [1:0]              chan_d;
  logic [CHANNEL_BITS-1:0] ch_res [4];

  // region load values
  logic [COORD_BITS-1:0]        rx, ry;
  logic [REGION_WIDTH_BITS-1:0] wd_nz;
  logic [WB-1:0]                wd_held;

  assign rx    = COORD_BITS'($signed(region_x));
  assign ry    = COORD_BITS'($signed(region_y));
  assign wd_nz = (region_width == '0) ? REGION_WIDTH_BITS'(1) : region_width;
  assign wd_held = ({2'b00, wd_nz} > 17'(MAX_ROW_WIDTH)) ? WB'(MAX_ROW_WIDTH) : WB'(wd_nz);

  // offsets from the start point and raster step
  logic [COORD_BITS-1:0]  off;
  logic                   row_end;
  logic signed [DXW-1:0]  dx_next, dy_next;

  assign off     = cur_x - row_left;
  assign row_end = (CMPW'(off) + CMPW'(1)) >= CMPW'(row_width_held);
  assign dx_next = DXW'($signed({cur_x, 8'h00})) - DXW'($signed(cfg.start_x));
  assign dy_next = DXW'($signed({cur_y, 8'h00})) - DXW'($signed(cfg.start_y));

  always_ff @(posedge clk) begin
    if (rst) begin
      cur_x          <= '0;
      cur_y          <= '0;
      row_left       <= '0;
      row_width_held <= WB'(1);
    end else if (cmd.capture && new_region) begin
      cur_x          <= rx;
      cur_y          <= ry;
      row_left       <= rx;
      row_width_held <= wd_held;
    end else if (cmd.diff) begin
      if (row_end) begin
        cur_x <= row_left;
        cur_y <= cur_y + COORD_BITS'(1);
      end else begin
        cur_x <= cur_x + COORD_BITS'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.diff) begin
      dx <= dx_next;
      dy <= dy_next;
    end
  end

  // partial product: offset times one coefficient slice
  logic [COEF_BITS-1:0]         coef_sel;
  logic signed [DXW-1:0]        mul_a;
  logic signed [CHUNK_BITS-1:0] mul_b;

  assign coef_sel = cmd.mul_axis ? cfg.coef_y : cfg.coef_x;
  assign mul_a    = cmd.mul_axis ? dy : dx;

  always_comb begin
    case (cmd.mul_chunk)
      CHUNK_LO:  mul_b = $signed({1'b0, coef_sel[15:0]});
      CHUNK_MID: mul_b = $signed({1'b0, coef_sel[31:16]});
      CHUNK_HI:  mul_b = $signed({{9{coef_sel[COEF_BITS-1]}}, coef_sel[COEF_BITS-1:32]});
      default:   mul_b = '0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (cmd.mul_issue) begin
      prod    <= mul_a * mul_b;
      chunk_d <= cmd.mul_chunk;
    end
  end

  // accumulate shifted partial products
  logic signed [ACCW-1:0] prod_ext, addend;

  assign prod_ext = ACCW'(prod);

  always_comb begin
    case (chunk_d)
      CHUNK_LO:  addend = prod_ext;
      CHUNK_MID: addend = prod_ext <<< 16;
      CHUNK_HI:  addend = prod_ext <<< 32;
      default:   addend = '0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (cmd.diff) begin
      acc <= '0;
    end else if (cmd.acc_add) begin
      acc <= acc + addend;
    end
  end

  // clamp projection to weight 0..1 with 16 fraction bits
  logic [W_BITS-1:0] w_next;

  always_comb begin
    if (cfg.flat_mode) begin
      w_next = WEIGHT_HALF;
    end else if (acc[ACCW-1]) begin
      w_next = WEIGHT_ZERO;
    end else if (|acc[ACCW-2:COEF_BITS]) begin
      w_next = WEIGHT_ONE;
    end else begin
      w_next = {1'b0, acc[COEF_BITS-1:24]};
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.weight) begin
      w <= w_next;
    end
  end

  // channel product: (near - far) * w
  logic [CHANNEL_BITS-1:0]         n_sel, f_sel;
  logic signed [CHANNEL_BITS:0]    cdiff;
  logic signed [W_BITS:0]          wmul;

  always_comb begin
    case (cmd.blend_chan)
      CH_RED: begin
        n_sel = cfg.color_near[48 +: CHANNEL_BITS];
        f_sel = cfg.color_far[48 +: CHANNEL_BITS];
      end
      CH_GREEN: begin
        n_sel = cfg.color_near[32 +: CHANNEL_BITS];
        f_sel = cfg.color_far[32 +: CHANNEL_BITS];
      end
      CH_BLUE: begin
        n_sel = cfg.color_near[16 +: CHANNEL_BITS];
        f_sel = cfg.color_far[16 +: CHANNEL_BITS];
      end
      CH_ALPHA: begin
        n_sel = cfg.color_near[0 +: CHANNEL_BITS];
        f_sel = cfg.color_far[0 +: CHANNEL_BITS];
      end
      default: begin
        n_sel = '0;
        f_sel = '0;
      end
    endcase
  end

  assign cdiff = $signed({1'b0, n_sel}) - $signed({1'b0, f_sel});
  assign wmul  = $signed({1'b0, w});

  always_ff @(posedge clk) begin
    if (cmd.blend_issue) begin
      bprod  <= cdiff * wmul;
      bf     <= f_sel;
      chan_d <= cmd.blend_chan;
    end
  end

  // far * 65536 + product, rounded
  logic signed [SW-1:0] bsum;

  assign bsum = SW'($signed({1'b0, bf, 16'h0000})) + SW'(bprod) + SW'(ROUND_HALF);

  always_ff @(posedge clk) begin
    if (cmd.blend_add) begin
      ch_res[chan_d] <= bsum[CHANNEL_BITS+15:16];
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (cmd.load_out) begin
      red   <= ch_res[CH_RED];
      green <= ch_res[CH_GREEN];
      blue  <= ch_res[CH_BLUE];
      alpha <= ch_res[CH_ALPHA];
    end
  end

endmodule

`default_nettype wire

### verif/tb.sv
// Self-checking testbench for the linear two-colour gradient pixel generator
module tb import lgr_pkg::*; ();
  timeunit 1ns;
  timeprecision 1ps;

  localparam int          COORD_W      = 25;
  localparam int          CHAN_W       = 16;
  localparam int          MAX_SPAN     = 16384;
  localparam int          DRAIN_CYCLES = 40;        // idle time after the last result comes back
  localparam int          CYCLE_LIMIT  = 1500000;
  localparam int          HOLD_CYCLES  = 400;
  localparam longint      COEF_UNIT    = 64'sd4294967296;   // 1.0 with 32 fraction bits
  localparam longint      COEF_MAX     = 64'sd549755813887;
  localparam longint      COEF_MIN     = -64'sd549755813888;
  localparam longint      START_LIMIT  = 256000;
  localparam logic [24:0] EDGE_LO      = 25'h1000000;
  localparam logic [24:0] EDGE_HI      = 25'h0FFFFFF;
  localparam logic [2:0]  REG_NONE     = 3'd7;      // no register behind this index

  // one blended pixel, element 0 is red
  typedef logic [0:3][CHAN_W-1:0] pixel_t;

  logic clk = 1'b0;
  logic rst = 1'b1;

  logic                         pix_valid    = 1'b0;
  logic                         pix_ready;
  logic                         new_region   = 1'b0;
  logic [REGION_COORD_BITS-1:0] region_x     = '0;
  logic [REGION_COORD_BITS-1:0] region_y     = '0;
  logic [REGION_WIDTH_BITS-1:0] region_width = '0;
  logic                         rgba_valid;
  logic                         rgba_ready   = 1'b0;
  logic [CHAN_W-1:0]            red, green, blue, alpha;
  logic                         psel         = 1'b0;
  logic                         penable      = 1'b0;
  logic                         pwrite       = 1'b0;
  logic [APB_ADDR_BITS-1:0]     paddr        = '0;
  logic [APB_DATA_BITS-1:0]     pwdata       = '0;
  logic [APB_DATA_BITS-1:0]     prdata;
  logic                         pready;

  // gradient registers as the predictor sees them
  logic [START_BITS-1:0] cfg_start_x, cfg_start_y;
  logic [COEF_BITS-1:0]  cfg_coef_x, cfg_coef_y;
  logic [COLOR_BITS-1:0] cfg_near, cfg_far;
  logic                  cfg_flat;

  // raster position
  logic [COORD_W-1:0]           pos_x, pos_y, row_left;
  logic [REGION_WIDTH_BITS-1:0] row_span;

  pixel_t pending_pixels[$];
  int     mismatch_count = 0;
  int     cycle_count    = 0;
  bit     tx_calm        = 1'b0;
  int     rx_hold_req    = 0;

  linear_gradient_renderer_top #(
    .COORD_BITS    (COORD_W),
    .CHANNEL_BITS  (CHAN_W),
    .MAX_ROW_WIDTH (MAX_SPAN)
  ) DUT (
    .clk          (clk),
    .rst          (rst),
    .pix_valid    (pix_valid),
    .pix_ready    (pix_ready),
    .new_region   (new_region),
    .region_x     (region_x),
    .region_y     (region_y),
    .region_width (region_width),
    .rgba_valid   (rgba_valid),
    .rgba_ready   (rgba_ready),
    .red          (red),
    .green        (green),
    .blue         (blue),
    .alpha        (alpha),
    .psel         (psel),
    .penable      (penable),
    .pwrite       (pwrite),
    .paddr        (paddr),
    .pwdata       (pwdata),
    .prdata       (prdata),
    .pready       (pready)
  );

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  // idle stretch: mostly short, now and then long
  function automatic int idle_len();
    int r;
    r = $urandom_range(0, 99);
    if (r < 70) return $urandom_range(1, 2);
    if (r < 92) return $urandom_range(3, 10);
    if (r < 98) return $urandom_range(11, 30);
    return $urandom_range(40, 80);
  endfunction

  function automatic void reset_predictor();
    cfg_start_x = RST_START;
    cfg_start_y = RST_START;
    cfg_coef_x  = RST_COEF;
    cfg_coef_y  = RST_COEF;
    cfg_near    = RST_NEAR;
    cfg_far     = '1;
    cfg_flat    = 1'b0;
    pos_x       = '0;
    pos_y       = '0;
    row_left    = '0;
    row_span    = 15'd1;
  endfunction

  function automatic void note_reg(input logic [2:0] idx, input logic [63:0] val);
    case (idx)
      REG_START_X:    cfg_start_x = val[START_BITS-1:0];
      REG_START_Y:    cfg_start_y = val[START_BITS-1:0];
      REG_COEF_X:     cfg_coef_x  = val[COEF_BITS-1:0];
      REG_COEF_Y:     cfg_coef_y  = val[COEF_BITS-1:0];
      REG_COLOR_NEAR: cfg_near    = val;
      REG_COLOR_FAR:  cfg_far     = val;
      REG_FLAT_MODE:  cfg_flat    = val[0];
      default: ;
    endcase
  endfunction

  // projection onto the gradient axis, clamped to 0..1 with 16 fraction bits
  function automatic logic [W_BITS-1:0] gradient_weight();
    longint              px, py, sx, sy;
    logic signed [127:0] dx, dy, kx, ky, proj;
    if (cfg_flat) return WEIGHT_HALF;
    px   = $signed(pos_x);
    py   = $signed(pos_y);
    sx   = $signed(cfg_start_x);
    sy   = $signed(cfg_start_y);
    dx   = px * 256 - sx;
    dy   = py * 256 - sy;
    kx   = $signed(cfg_coef_x);
    ky   = $signed(cfg_coef_y);
    proj = dx * kx + dy * ky;
    if (proj < 0) return WEIGHT_ZERO;
    if (proj >= (128'sd1 <<< 40)) return WEIGHT_ONE;
    return W_BITS'(proj[39:24]);
  endfunction

  // colour of the pixel this beat produces, then step the raster position
  function automatic pixel_t render_next_pixel(input bit nr, input logic [24:0] rx,
                                               input logic [24:0] ry,
                                               input logic [14:0] rw);
    pixel_t             px;
    longint             w, n, f;
    logic [COORD_W-1:0] off;
    if (nr) begin
      row_left = rx;
      pos_x    = rx;
      pos_y    = ry;
      row_span = (rw == 0) ? 15'd1 : (rw > MAX_SPAN) ? 15'(MAX_SPAN) : rw;
    end
    w = gradient_weight();
    for (int c = 0; c < 4; c++) begin
      n     = cfg_near[48 - 16 * c +: CHAN_W];
      f     = cfg_far[48 - 16 * c +: CHAN_W];
      px[c] = CHAN_W'((n * w + f * (65536 - w) + ROUND_HALF) >> 16);
    end
    off = pos_x - row_left;
    if ({1'b0, off} + 26'd1 >= {11'd0, row_span}) begin
      pos_x = row_left;
      pos_y = pos_y + 1'b1;
    end else begin
      pos_x = pos_x + 1'b1;
    end
    return px;
  endfunction

  // one pixel beat, with a random gap ahead of it
  task automatic send_pixel(input bit nr, input logic [24:0] rx, input logic [24:0] ry,
                            input logic [14:0] rw);
    int gap;
    gap = (tx_calm || $urandom_range(0, 99) < 55) ? 0 : idle_len();
    if (gap > 0) begin
      pix_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    pix_valid    <= 1'b1;
    new_region   <= nr;
    region_x     <= rx;
    region_y     <= ry;
    region_width <= rw;
    do @(posedge clk); while (!pix_ready);
    pending_pixels.push_back(render_next_pixel(nr, rx, ry, rw));
  endtask

  // follow-on beat in the current region, region fields random
  task automatic send_noise();
    send_pixel(1'b0, 25'($urandom), 25'($urandom), 15'($urandom));
  endtask

  // stop sending and let every outstanding pixel come back
  task automatic wait_drained();
    pix_valid <= 1'b0;
    while (pending_pixels.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic write_reg(input logic [2:0] idx, input logic [63:0] val);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {idx, 3'b000};
    pwdata  <= val;
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    psel    <= 1'b0;
    penable <= 1'b0;
    note_reg(idx, val);
    @(posedge clk);
  endtask

  // block must be idle when this is called
  task automatic set_gradient(input logic [63:0] sx, input logic [63:0] sy,
                              input logic [63:0] cx, input logic [63:0] cy,
                              input logic [63:0] near, input logic [63:0] far,
                              input logic [63:0] flat);
    write_reg(REG_START_X, sx);
    write_reg(REG_START_Y, sy);
    write_reg(REG_COEF_X, cx);
    write_reg(REG_COEF_Y, cy);
    write_reg(REG_COLOR_NEAR, near);
    write_reg(REG_COLOR_FAR, far);
    write_reg(REG_FLAT_MODE, flat);
  endtask

  function automatic longint random_coef();
    logic [COEF_BITS-1:0] raw;
    longint               k;
    case ($urandom_range(0, 9))
      0: k = 0;
      1: begin
        raw = COEF_BITS'({$urandom, $urandom});
        k   = $signed(raw);
      end
      default: begin
        // reciprocal of a plausible axis length
        k = COEF_UNIT / longint'($urandom_range(1, 3000));
        if ($urandom_range(0, 1) == 1) k = -k;
      end
    endcase
    return k;
  endfunction

  function automatic logic [63:0] random_colour();
    case ($urandom_range(0, 9))
      0: return '0;
      1: return '1;
      default: return {$urandom, $urandom};
    endcase
  endfunction

  function automatic longint random_start();
    if ($urandom_range(0, 4) == 0)
      return longint'($urandom_range(0, 2 * START_LIMIT)) - START_LIMIT;
    return longint'($urandom_range(0, 102400)) - 51200;
  endfunction

  task automatic pick_random_gradient();
    longint sx, sy;
    sx = random_start();
    sy = random_start();
    set_gradient(sx, sy, random_coef(), random_coef(), random_colour(), random_colour(),
                 ($urandom_range(0, 4) == 0));
  endtask

  // ---------------------------------------------------------------- tests

  // no region loaded yet: (0,0) upward with one pixel per row
  task automatic test_reset_state();
    repeat (3) send_noise();
  endtask

  // coordinate extremes, wrap-around and width holding
  task automatic test_region_edges();
    send_pixel(1'b1, EDGE_LO, EDGE_LO, 15'd0);
    send_noise();
    send_pixel(1'b1, EDGE_HI, EDGE_HI, 15'd3);
    repeat (2) send_noise();
    send_pixel(1'b1, 25'd0, 25'd0, 15'(MAX_SPAN + 1));
    send_pixel(1'b1, 25'd5, 25'd7, 15'h7FFF);
    send_pixel(1'b1, 25'd9, 25'd9, 15'(MAX_SPAN));
    send_pixel(1'b1, '1, '1, 15'd1);
  endtask

  // saturated coefficients, start point extremes and flat weight
  task automatic test_weight_extremes();
    wait_drained();
    set_gradient(START_LIMIT, -START_LIMIT, COEF_MAX, COEF_MIN, '0, '1, 0);
    send_pixel(1'b1, 25'd0, 25'd0, 15'd2);
    send_noise();
    send_pixel(1'b1, 25'd2000, 25'(-2000), 15'd1);
    send_pixel(1'b1, 25'd1000, 25'(-1000), 15'd1);
    wait_drained();
    set_gradient(-START_LIMIT, START_LIMIT, COEF_MIN, COEF_MAX, '1, '0, 1);
    write_reg(REG_NONE, '1);
    send_pixel(1'b1, 25'd3, 25'd4, 15'd2);
    send_noise();
  endtask

  // weight ramps through fractions to just past one, then a row wrap
  task automatic test_weight_ramp();
    wait_drained();
    set_gradient(0, 0, COEF_UNIT / 4 + 1, 0, random_colour(), random_colour(), 0);
    send_pixel(1'b1, 25'd0, 25'd0, 15'd5);
    repeat (5) send_noise();
  endtask

  // runs of pixels over fresh regions near the gradient, with some noise beats
  task automatic test_random_gradients(input int phases, input int beats);
    int          left, run, ox, oy, r;
    logic [24:0] gx, gy;
    logic [14:0] span;
    for (int p = 0; p < phases; p++) begin
      wait_drained();
      pick_random_gradient();
      left = beats;
      while (left > 0) begin
        tx_calm = ($urandom_range(0, 5) == 0);
        if ($urandom_range(0, 99) < 15) begin
          send_pixel(1'($urandom_range(0, 1)), 25'($urandom), 25'($urandom),
                     15'($urandom));
          left--;
        end else begin
          ox = $signed(cfg_start_x);
          oy = $signed(cfg_start_y);
          gx = 25'(ox / 256 + int'($urandom_range(0, 400)) - 200);
          gy = 25'(oy / 256 + int'($urandom_range(0, 400)) - 200);
          r  = $urandom_range(0, 99);
          if (r < 70)      span = 15'($urandom_range(1, 48));
          else if (r < 93) span = 15'($urandom_range(49, 400));
          else if (r < 97) span = 15'($urandom_range(1, MAX_SPAN));
          else             span = 15'($urandom_range(0, 32767));
          run = $urandom_range(1, 60);
          if (run > left) run = left;
          send_pixel(1'b1, gx, gy, span);
          repeat (run - 1) send_noise();
          left -= run;
        end
      end
    end
    tx_calm = 1'b0;
  endtask

  // receiver holds off while the sender keeps offering beats
  task automatic test_output_backpressure();
    wait_drained();
    pick_random_gradient();
    tx_calm     = 1'b1;
    rx_hold_req = HOLD_CYCLES;
    send_pixel(1'b1, 25'(-3), 25'd2, 15'd7);
    repeat (39) send_noise();
    tx_calm = 1'b0;
  endtask

  // sender stops mid-region until everything is back, then carries on
  task automatic test_sender_pause();
    wait_drained();
    pick_random_gradient();
    send_pixel(1'b1, 25'd0, 25'd0, 15'd11);
    repeat (29) send_noise();
    wait_drained();
    repeat (30) send_noise();
  endtask

  // ---------------------------------------------------------------- processes

  // receiver readiness: random stalls, quiet stretches and requested hold-offs
  always @(posedge clk) begin : drive_rgba_ready
    int rx_stall;
    int rx_calm;
    if (rx_hold_req != 0) begin
      rx_stall    = rx_hold_req;
      rx_hold_req = 0;
    end
    if (rx_stall > 0) begin
      rx_stall--;
      rgba_ready <= 1'b0;
    end else begin
      if (rx_calm > 0) rx_calm--;
      else if ($urandom_range(0, 199) == 0) rx_calm = $urandom_range(50, 300);
      if (rx_calm == 0 && $urandom_range(0, 99) < 30) begin
        rx_stall = idle_len() - 1;
        rgba_ready <= 1'b0;
      end else begin
        rgba_ready <= 1'b1;
      end
    end
  end

  // compare each result beat with the oldest prediction
  always @(posedge clk) begin : check_pixels
    pixel_t want;
    pixel_t got;
    string  chan_name[4];
    chan_name = '{"red", "green", "blue", "alpha"};
    if (!rst && rgba_valid && rgba_ready) begin
      got = {red, green, blue, alpha};
      if (pending_pixels.size() == 0) begin
        $display("%0t: pixel %h arrived, none expected", $time, got);
        mismatch_count++;
      end else begin
        want = pending_pixels.pop_front();
        for (int c = 0; c < 4; c++)
          if (got[c] !== want[c]) begin
            $display("%0t: %s expected %h got %h", $time, chan_name[c], want[c], got[c]);
            mismatch_count++;
          end
      end
    end
  end

  // run limit
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("Mismatches found");
      $finish;
    end
  end

  initial begin
    reset_predictor();
    repeat (9) @(posedge clk);
    rst <= 1'b0;
    test_reset_state();
    test_region_edges();
    test_weight_extremes();
    test_weight_ramp();
    test_random_gradients(12, 150);
    test_output_backpressure();
    test_sender_pause();
    wait_drained();
    if (mismatch_count == 0) $display("No mismatches found");
    else $display("Mismatches found");
    $finish;
  end

endmodule

### linear_gradient_renderer_top.f
+incdir+design
design/lgr_pkg.sv
design/lgr_regs.sv
design/lgr_ctrl.sv
design/lgr_datapath.sv
design/linear_gradient_renderer_top.sv
verif/tb.sv
